// ===== design/tccs_pkg.sv =====
package tccs_pkg;

  // fixed field widths
  localparam int IDX_W  = 11;
  localparam int BYTE_W = 8;

  // control characters and reset contents
  localparam logic [BYTE_W-1:0] CH_CR      = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF      = 8'h0a;
  localparam logic [BYTE_W-1:0] CH_BS      = 8'h08;
  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h07;

  // input action codes
  localparam logic ACT_PUT  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [2:0] {
    CMD_READ,
    CMD_CR,
    CMD_LF,
    CMD_BS,
    CMD_CHAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
  } cmd_t;

  // back end to front end
  typedef struct packed {
    logic take;
    logic clearing;
  } back_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_FILL
  } back_state_t;

  function automatic cmd_kind_t classify(input logic act, input logic [BYTE_W-1:0] code);
    cmd_kind_t k;
    if (act == ACT_READ) begin
      k = CMD_READ;
    end else if (code == CH_CR) begin
      k = CMD_CR;
    end else if (code == CH_LF) begin
      k = CMD_LF;
    end else if (code == CH_BS) begin
      k = CMD_BS;
    end else begin
      k = CMD_CHAR;
    end
    return k;
  endfunction

endpackage

// ===== design/tccs_front.sv =====
module tccs_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic                            action,
  input  logic [tccs_pkg::BYTE_W-1:0]     char_code,
  input  logic [tccs_pkg::IDX_W-1:0]      cell_index,
  input  tccs_pkg::back_status_t          status,
  output tccs_pkg::cmd_t                  cmd,
  output logic                            cmd_valid
);
  import tccs_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;
  cmd_t       cmd_in;

  // classify the incoming item
  always_comb begin
    cmd_in.kind       = classify(action, char_code);
    cmd_in.char_code  = char_code;
    cmd_in.cell_index = cell_index;
  end

  // no items taken while the store is being cleared
  assign full      = (count == 2'd2) || status.clearing;
  assign do_push   = push && !full;
  assign cmd_valid = (count != 2'd0);
  assign do_pop    = status.take && cmd_valid;
  assign cmd       = q[rd_ptr];

  // two-entry command queue, control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

endmodule

// ===== design/tccs_back.sv =====
module tccs_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tccs_pkg::cmd_t              cmd,
  input  logic                        cmd_valid,
  output tccs_pkg::back_status_t      status,
  input  logic [tccs_pkg::BYTE_W-1:0] blank_attr,
  output logic                        empty,
  input  logic                        pop,
  output logic [tccs_pkg::IDX_W-1:0]  cursor_position,
  output logic [tccs_pkg::BYTE_W-1:0] cell_char,
  output logic [tccs_pkg::BYTE_W-1:0] cell_attribute,
  output logic                        scrolled
);
  import tccs_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CLW   = $clog2(COLUMNS);

  localparam logic [CW-1:0]  LAST_LIN = CW'(CELLS - 1);
  localparam logic [CW-1:0]  BOT_LIN  = CW'((ROWS - 1) * COLUMNS);
  localparam logic [CW-1:0]  COPY_END = CW'(CELLS - COLUMNS);
  localparam logic [CW-1:0]  COLS_CW  = CW'(COLUMNS);
  localparam logic [CLW-1:0] LAST_COL = CLW'(COLUMNS - 1);
  localparam logic [RW-1:0]  LAST_ROW = RW'(ROWS - 1);

  back_state_t state, state_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic [CW-1:0]  cur_lin, cur_lin_next;
  logic [RW-1:0]  cur_row, cur_row_next;
  logic [CLW-1:0] cur_col, cur_col_next;
  logic           rd_in_range, rd_in_range_next;

  logic              out_valid, out_valid_next;
  logic [IDX_W-1:0]  out_cursor, out_cursor_next;
  logic [BYTE_W-1:0] out_char, out_char_next;
  logic [BYTE_W-1:0] out_attr, out_attr_next;
  logic              out_scrolled, out_scrolled_next;

  logic [BYTE_W-1:0] char_mem [CELLS];
  logic [BYTE_W-1:0] attr_mem [CELLS];
  logic [BYTE_W-1:0] rd_char_q;
  logic [BYTE_W-1:0] rd_attr_q;
  logic [CW-1:0]     mem_raddr;
  logic              cw_en;
  logic [CW-1:0]     cw_addr;
  logic [BYTE_W-1:0] cw_data;
  logic              aw_en;
  logic [CW-1:0]     aw_addr;
  logic [BYTE_W-1:0] aw_data;

  logic          slot_free;
  logic          in_range;
  logic [CW-1:0] lin_bs;

  assign slot_free = !out_valid || pop;
  assign in_range  = 32'(cmd.cell_index) < 32'(CELLS);
  assign lin_bs    = (cur_lin != '0) ? cur_lin - CW'(1) : cur_lin;

  // state register and item context
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      cnt         <= '0;
      cur_lin     <= '0;
      cur_row     <= '0;
      cur_col     <= '0;
      rd_in_range <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      cur_lin     <= cur_lin_next;
      cur_row     <= cur_row_next;
      cur_col     <= cur_col_next;
      rd_in_range <= rd_in_range_next;
      out_valid   <= out_valid_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_cursor   <= out_cursor_next;
    out_char     <= out_char_next;
    out_attr     <= out_attr_next;
    out_scrolled <= out_scrolled_next;
  end

  // cell stores: one write and one registered read each
  always_ff @(posedge clk) begin
    if (cw_en) begin
      char_mem[cw_addr] <= cw_data;
    end
    rd_char_q <= char_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (aw_en) begin
      attr_mem[aw_addr] <= aw_data;
    end
    rd_attr_q <= attr_mem[mem_raddr];
  end

  // sequencer: next state, store writes, cursor and result
  always_comb begin
    state_next        = state;
    cnt_next          = cnt;
    cur_lin_next      = cur_lin;
    cur_row_next      = cur_row;
    cur_col_next      = cur_col;
    rd_in_range_next  = rd_in_range;
    out_valid_next    = out_valid && !pop;
    out_cursor_next   = out_cursor;
    out_char_next     = out_char;
    out_attr_next     = out_attr;
    out_scrolled_next = out_scrolled;
    mem_raddr         = '0;
    cw_en             = 1'b0;
    cw_addr           = cur_lin;
    cw_data           = CH_SPACE;
    aw_en             = 1'b0;
    aw_addr           = cnt;
    aw_data           = blank_attr;
    status.take       = 1'b0;
    status.clearing   = 1'b0;

    case (state)
      ST_CLEAR: begin
        status.clearing = 1'b1;
        cw_en   = 1'b1;
        cw_addr = cnt;
        aw_en   = 1'b1;
        aw_data = ATTR_RESET;
        if (cnt == LAST_LIN) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end

      ST_IDLE: begin
        if (cmd_valid && slot_free) begin
          status.take       = 1'b1;
          out_char_next     = '0;
          out_attr_next     = '0;
          out_scrolled_next = 1'b0;
          case (cmd.kind)
            CMD_READ: begin
              rd_in_range_next = in_range;
              mem_raddr        = in_range ? CW'(cmd.cell_index) : '0;
              state_next       = ST_READ;
            end
            CMD_CR: begin
              cur_lin_next    = cur_lin - CW'(cur_col);
              cur_col_next    = '0;
              out_cursor_next = IDX_W'(cur_lin - CW'(cur_col));
              out_valid_next  = 1'b1;
            end
            CMD_LF: begin
              cur_col_next = '0;
              if (cur_row == LAST_ROW) begin
                cur_lin_next = BOT_LIN;
                cnt_next     = '0;
                state_next   = ST_COPY;
              end else begin
                cur_lin_next    = cur_lin - CW'(cur_col) + COLS_CW;
                cur_row_next    = cur_row + RW'(1);
                out_cursor_next = IDX_W'(cur_lin - CW'(cur_col) + COLS_CW);
                out_valid_next  = 1'b1;
              end
            end
            CMD_BS: begin
              cw_en   = 1'b1;
              cw_addr = lin_bs;
              cur_lin_next = lin_bs;
              if (cur_lin != '0) begin
                if (cur_col == '0) begin
                  cur_col_next = LAST_COL;
                  cur_row_next = cur_row - RW'(1);
                end else begin
                  cur_col_next = cur_col - CLW'(1);
                end
              end
              out_cursor_next = IDX_W'(lin_bs);
              out_valid_next  = 1'b1;
            end
            CMD_CHAR: begin
              cw_en   = 1'b1;
              cw_addr = cur_lin;
              cw_data = cmd.char_code;
              if (cur_lin == LAST_LIN) begin
                // leaving the last cell scrolls
                cur_lin_next = BOT_LIN;
                cur_row_next = LAST_ROW;
                cur_col_next = '0;
                cnt_next     = '0;
                state_next   = ST_COPY;
              end else begin
                cur_lin_next = cur_lin + CW'(1);
                if (cur_col == LAST_COL) begin
                  cur_col_next = '0;
                  cur_row_next = cur_row + RW'(1);
                end else begin
                  cur_col_next = cur_col + CLW'(1);
                end
                out_cursor_next = IDX_W'(cur_lin + CW'(1));
                out_valid_next  = 1'b1;
              end
            end
            default: begin
              out_cursor_next = IDX_W'(cur_lin);
              out_valid_next  = 1'b1;
            end
          endcase
        end
      end

      ST_READ: begin
        out_cursor_next   = IDX_W'(cur_lin);
        out_char_next     = rd_in_range ? rd_char_q : '0;
        out_attr_next     = rd_in_range ? rd_attr_q : '0;
        out_scrolled_next = 1'b0;
        out_valid_next    = 1'b1;
        state_next        = ST_IDLE;
      end

      ST_COPY: begin
        // read one row ahead, write the cell read last cycle
        mem_raddr = (cnt != COPY_END) ? cnt + COLS_CW : '0;
        if (cnt != '0) begin
          cw_en   = 1'b1;
          cw_addr = cnt - CW'(1);
          cw_data = rd_char_q;
          aw_en   = 1'b1;
          aw_addr = cnt - CW'(1);
          aw_data = rd_attr_q;
        end
        if (cnt == COPY_END) begin
          state_next = ST_FILL;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end

      ST_FILL: begin
        // blank the bottom row
        cw_en   = 1'b1;
        cw_addr = cnt;
        aw_en   = 1'b1;
        if (cnt == LAST_LIN) begin
          cnt_next          = '0;
          out_cursor_next   = IDX_W'(cur_lin);
          out_char_next     = '0;
          out_attr_next     = '0;
          out_scrolled_next = 1'b1;
          out_valid_next    = 1'b1;
          state_next        = ST_IDLE;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign empty           = !out_valid;
  assign cursor_position = out_cursor;
  assign cell_char       = out_char;
  assign cell_attribute  = out_attr;
  assign scrolled        = out_scrolled;

`ifndef SYNTHESIS
  // row and column track the linear cursor
  a_cursor_split: assert property (@(posedge clk) disable iff (rst)
    32'(cur_lin) == 32'(cur_row) * COLUMNS + 32'(cur_col))
    else $error("cursor row/column out of step with linear cursor");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    32'(cur_lin) < 32'(CELLS))
    else $error("cursor beyond the screen");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    status.take |-> (state == ST_IDLE))
    else $error("item taken while busy");

  a_scroll_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COPY || state == ST_FILL) |-> !out_valid)
    else $error("result pending during scroll");
`endif

endmodule

// ===== design/text_console_cursor_scroll.sv =====
// Put items without a scroll go through at one item per cycle while the single result slot
// is empty or being popped. Reads pass through a read state (registered store read), in
// which no new item is taken. A scroll copies COLUMNS*ROWS-COLUMNS cells one a cycle
// through the store's single port pair and blanks the bottom row.
// Reset is synchronous; afterwards a clearing pass over all COLUMNS*ROWS cells
// fills the stores while full stays high. blank_attribute resets to 0x07.
module text_console_cursor_scroll #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  logic                        action,
  input  logic [tccs_pkg::BYTE_W-1:0] char_code,
  input  logic [tccs_pkg::IDX_W-1:0]  cell_index,
  output logic                        empty,
  input  logic                        pop,
  output logic [tccs_pkg::IDX_W-1:0]  cursor_position,
  output logic [tccs_pkg::BYTE_W-1:0] cell_char,
  output logic [tccs_pkg::BYTE_W-1:0] cell_attribute,
  output logic                        scrolled,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tccs_pkg::BYTE_W-1:0] cfg_data
);
  import tccs_pkg::*;

  logic [BYTE_W-1:0] blank_attribute;
  cmd_t              cmd;
  logic              cmd_valid;
  back_status_t      status;

  // blank attribute register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_attribute <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      blank_attribute <= cfg_data;
    end
  end

  // front end: classify and queue
  tccs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .char_code  (char_code),
    .cell_index (cell_index),
    .status     (status),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid)
  );

  // back end: stores, cursor, scroll sequencer, result register
  tccs_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .cmd_valid       (cmd_valid),
    .status          (status),
    .blank_attr      (blank_attribute),
    .empty           (empty),
    .pop             (pop),
    .cursor_position (cursor_position),
    .cell_char       (cell_char),
    .cell_attribute  (cell_attribute),
    .scrolled        (scrolled)
  );

endmodule

// ===== tb/console_checker.sv =====
`timescale 1ns / 100ps

module console_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic                        full,
  input  logic                        action,
  input  logic [tccs_pkg::BYTE_W-1:0] char_code,
  input  logic [tccs_pkg::IDX_W-1:0]  cell_index,
  input  logic                        empty,
  input  logic                        pop,
  input  logic [tccs_pkg::IDX_W-1:0]  cursor_position,
  input  logic [tccs_pkg::BYTE_W-1:0] cell_char,
  input  logic [tccs_pkg::BYTE_W-1:0] cell_attribute,
  input  logic                        scrolled,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [tccs_pkg::BYTE_W-1:0] cfg_data,
  input  logic                        end_of_test,
  output int                          failures
);
  import tccs_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [IDX_W-1:0]  cursor;
    logic [BYTE_W-1:0] chr;
    logic [BYTE_W-1:0] attr;
    logic              did_scroll;
  } cell_result_t;

  // shadow copy of the screen, cursor and blank attribute
  logic [BYTE_W-1:0] screen_chars [CELLS];
  logic [BYTE_W-1:0] screen_attrs [CELLS];
  int                cursor_cell;
  logic [BYTE_W-1:0] blank_attr;
  cell_result_t      pending_results [$];
  logic              end_seen;

  task automatic report_mismatch(input string what, input int got, input int want);
    failures++;
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // rows move up by one, bottom row becomes blank
  task automatic scroll_screen();
    for (int k = 0; k < CELLS - COLUMNS; k++) begin
      screen_chars[k] = screen_chars[k + COLUMNS];
      screen_attrs[k] = screen_attrs[k + COLUMNS];
    end
    for (int k = CELLS - COLUMNS; k < CELLS; k++) begin
      screen_chars[k] = CH_SPACE;
      screen_attrs[k] = blank_attr;
    end
  endtask

  // apply one item to the shadow screen and queue the result it causes
  task automatic console_step(input logic act, input logic [BYTE_W-1:0] code,
                              input logic [IDX_W-1:0] idx);
    cell_result_t r;
    int row;
    r = '0;
    if (cursor_cell >= CELLS) cursor_cell = 0;
    if (act == ACT_READ) begin
      if (idx < CELLS) begin
        r.chr  = screen_chars[idx];
        r.attr = screen_attrs[idx];
      end
    end else if (code == CH_CR) begin
      cursor_cell = (cursor_cell / COLUMNS) * COLUMNS;
    end else if (code == CH_LF) begin
      row = cursor_cell / COLUMNS;
      if (row >= ROWS - 1) begin
        scroll_screen();
        r.did_scroll = 1'b1;
        row = ROWS - 2;
      end
      cursor_cell = (row + 1) * COLUMNS;
    end else if (code == CH_BS) begin
      if (cursor_cell > 0) cursor_cell--;
      screen_chars[cursor_cell] = CH_SPACE;
    end else begin
      // ordinary byte keeps the cell's attribute
      screen_chars[cursor_cell] = code;
      cursor_cell++;
      if (cursor_cell >= CELLS) begin
        scroll_screen();
        r.did_scroll = 1'b1;
        cursor_cell = (ROWS - 1) * COLUMNS;
      end
    end
    r.cursor = cursor_cell[IDX_W-1:0];
    pending_results.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    cell_result_t want;
    if (rst) begin
      for (int k = 0; k < CELLS; k++) begin
        screen_chars[k] = CH_SPACE;
        screen_attrs[k] = ATTR_RESET;
      end
      cursor_cell = 0;
      blank_attr  = ATTR_RESET;
      failures    = 0;
      end_seen    = 1'b0;
      pending_results.delete();
    end else begin
      // result side first: a result can never belong to an item pushed this cycle
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending, cursor", cursor_position, 0);
        end else begin
          want = pending_results.pop_front();
          if (cursor_position !== want.cursor)
            report_mismatch("cursor_position", cursor_position, want.cursor);
          if (cell_char !== want.chr)
            report_mismatch("cell_char", cell_char, want.chr);
          if (cell_attribute !== want.attr)
            report_mismatch("cell_attribute", cell_attribute, want.attr);
          if (scrolled !== want.did_scroll)
            report_mismatch("scrolled", scrolled, want.did_scroll);
        end
      end
      if (push && !full) console_step(action, char_code, cell_index);
      if (cfg_valid && cfg_ready) blank_attr = cfg_data;
      // anything still queued at the end never came out
      if (end_of_test && !end_seen) begin
        end_seen = 1'b1;
        if (pending_results.size() != 0)
          report_mismatch("results never delivered", pending_results.size(), 0);
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import tccs_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  typedef enum int {
    BURST_TEXT,
    BURST_FEEDS,
    BURST_BACK,
    BURST_READS,
    BURST_NOISE
  } burst_kind_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              push;
  logic              full;
  logic              action;
  logic [BYTE_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;
  logic              empty;
  logic              pop;
  logic [IDX_W-1:0]  cursor_position;
  logic [BYTE_W-1:0] cell_char;
  logic [BYTE_W-1:0] cell_attribute;
  logic              scrolled;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [BYTE_W-1:0] cfg_data;
  logic              end_of_test;
  int                failures;

  int sent      = 0;
  int popped    = 0;
  int snd_calm  = 0;
  int rcv_calm  = 0;

  text_console_cursor_scroll #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .action(action), .char_code(char_code), .cell_index(cell_index),
    .empty(empty), .pop(pop),
    .cursor_position(cursor_position), .cell_char(cell_char),
    .cell_attribute(cell_attribute), .scrolled(scrolled),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  console_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .action(action), .char_code(char_code), .cell_index(cell_index),
    .empty(empty), .pop(pop),
    .cursor_position(cursor_position), .cell_char(cell_char),
    .cell_attribute(cell_attribute), .scrolled(scrolled),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .end_of_test(end_of_test), .failures(failures)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // wait before the next item, with occasional stretches of back-to-back items
  function automatic int pick_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [BYTE_W-1:0] plain_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(0, 255));
    if (b == CH_CR || b == CH_LF || b == CH_BS) b = b ^ 8'h40;
    return b;
  endfunction

  function automatic logic [IDX_W-1:0] any_index();
    return IDX_W'($urandom_range(0, 2047));
  endfunction

  // offer one item; push stays high when the next one follows at once
  task automatic put_item(input logic act, input logic [BYTE_W-1:0] code,
                          input logic [IDX_W-1:0] idx);
    int g;
    g = pick_gap(snd_calm);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk);
    end
    push       <= 1'b1;
    action     <= act;
    char_code  <= code;
    cell_index <= idx;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // register write once every result is out
  task automatic write_blank_attr(input logic [BYTE_W-1:0] value);
    push <= 1'b0;
    while (popped != sent) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one short sequence of console traffic
  task automatic run_burst();
    burst_kind_t kind;
    int pick;
    int len;
    int term;
    pick = $urandom_range(0, 9);
    if (pick < 5) kind = BURST_TEXT;
    else if (pick == 5) kind = BURST_FEEDS;
    else if (pick == 6) kind = BURST_BACK;
    else if (pick < 9) kind = BURST_READS;
    else kind = BURST_NOISE;
    case (kind)
      BURST_TEXT: begin
        // mostly short lines, sometimes a full row that wraps
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 100) : $urandom_range(1, 50);
        for (int k = 0; k < len; k++) put_item(ACT_PUT, plain_byte(), any_index());
        term = $urandom_range(0, 9);
        if (term >= 5 && term <= 7) put_item(ACT_PUT, CH_CR, any_index());
        if (term <= 6) put_item(ACT_PUT, CH_LF, any_index());
      end
      BURST_FEEDS: begin
        len = $urandom_range(1, 30);
        for (int k = 0; k < len; k++) put_item(ACT_PUT, CH_LF, any_index());
      end
      BURST_BACK: begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) put_item(ACT_PUT, CH_BS, any_index());
      end
      BURST_READS: begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          put_item(ACT_READ, BYTE_W'($urandom_range(0, 255)),
                   $urandom_range(0, 1) ? any_index() : IDX_W'($urandom_range(1900, 2047)));
        end
      end
      default: begin
        put_item(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)), any_index());
      end
    endcase
  endtask

  task automatic random_phase(input int items);
    int target;
    target = sent + items;
    while (sent < target) run_burst();
  endtask

  // result side: random gaps, plus two long hold-offs to fill the block
  initial begin : receiver
    int g;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (popped == 100 || popped == 400) g = 600;
      else g = pick_gap(rcv_calm);
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      popped++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    rst         = 1'b1;
    push        = 1'b0;
    action      = ACT_PUT;
    char_code   = '0;
    cell_index  = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    end_of_test = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: controls at the edges, extreme bytes, reads in and out of range
    put_item(ACT_PUT, CH_BS, '0);
    put_item(ACT_READ, 8'h00, 11'd0);
    put_item(ACT_PUT, 8'h00, 11'd0);
    put_item(ACT_PUT, 8'hff, '1);
    put_item(ACT_PUT, 8'h41, 11'd5);
    put_item(ACT_PUT, CH_BS, 11'd0);
    put_item(ACT_READ, 8'h00, 11'd0);
    put_item(ACT_READ, 8'h00, 11'd1);
    put_item(ACT_READ, 8'h00, 11'd2);
    put_item(ACT_PUT, CH_CR, 11'd0);
    put_item(ACT_PUT, CH_LF, 11'd0);
    put_item(ACT_PUT, 8'h7e, 11'd0);
    put_item(ACT_PUT, CH_CR, 11'd0);
    put_item(ACT_PUT, CH_BS, 11'd0);
    put_item(ACT_READ, 8'h00, 11'd79);
    put_item(ACT_READ, 8'h00, 11'd1999);
    put_item(ACT_READ, 8'h00, 11'd2000);
    put_item(ACT_READ, 8'hff, '1);
    put_item(ACT_READ, CH_LF, 11'd80);

    // random traffic under several blank attributes
    random_phase(120);
    write_blank_attr(8'hff);
    random_phase(120);
    write_blank_attr(8'h00);
    random_phase(120);
    write_blank_attr(BYTE_W'($urandom_range(0, 255)));
    random_phase(120);
    write_blank_attr(BYTE_W'($urandom_range(0, 255)));
    random_phase(120);

    // drain and let the block settle
    push <= 1'b0;
    while (popped != sent) @(negedge clk);
    repeat (20) @(negedge clk);
    end_of_test <= 1'b1;
    @(negedge clk);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #60_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
